// ===== rtl/obfe_pkg.sv =====
// shared constants, types and functions of the oriented box field evaluator
package obfe_pkg;

    localparam int MAX_BOXES     = 8;
    localparam int TANH_ENTRIES  = 1024;
    localparam int WORDS_PER_BOX = 18;
    localparam int MEM_DEPTH     = WORDS_PER_BOX * MAX_BOXES;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int BOX_IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int BOX_CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int TIDX_W        = (TANH_ENTRIES > 1) ? $clog2(TANH_ENTRIES) : 1;
    localparam int SCALED_W      = 35 + $clog2(TANH_ENTRIES + 1);

    localparam logic [4:0] W_CENTER  = 5'd0;
    localparam logic [4:0] W_LENGTH  = 5'd3;
    localparam logic [4:0] W_MATRIX  = 5'd6;
    localparam logic [4:0] W_MAT_END = 5'd14;
    localparam logic [4:0] W_INSIDE  = 5'd15;
    localparam logic [4:0] W_OUTSIDE = 5'd16;
    localparam logic [4:0] W_SCALE   = 5'd17;
    localparam logic [4:0] LAST_STEP = 5'd17;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    localparam logic CFG_BOX_COUNT = 1'b0;
    localparam logic CFG_DIM_COUNT = 1'b1;

    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_SHARP,
        ST_AXSEL,
        ST_MUL_P,
        ST_LOOK_P,
        ST_SAVE_P,
        ST_MUL_M,
        ST_LOOK_M,
        ST_SAVE_M,
        ST_WIN,
        ST_BPROD,
        ST_BFIN,
        ST_DONE
    } obfe_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_POINT,
        OP_BOX_INIT,
        OP_TMUL_P,
        OP_TMUL_M,
        OP_TLOOK,
        OP_TSAVE_P,
        OP_TSAVE_M,
        OP_WIN,
        OP_SHARP,
        OP_BPROD,
        OP_BFIN
    } dp_op_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [BOX_IDX_W-1:0] box;
        logic [4:0]           word;
        logic [1:0]           axis;
        dp_op_t               op;
    } dp_cmd_t;

    typedef struct packed {
        logic       k_zero;
        logic [2:0] len_nz;
    } dp_stat_t;

    typedef logic [16:0] tanh_rom_t [TANH_ENTRIES];

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    // load order: center, length, inside, outside, scale, then matrix
    function automatic logic [4:0] load_word(input logic [4:0] step);
        if (step < W_MATRIX)
            return step;
        else if (step < 5'd9)
            return step + 5'd9;
        else
            return step - 5'd3;
    endfunction

    function automatic logic [1:0] mat_col(input logic [4:0] w);
        case (w)
            5'd6, 5'd9, 5'd12:  return 2'd0;
            5'd7, 5'd10, 5'd13: return 2'd1;
            5'd8, 5'd11, 5'd14: return 2'd2;
            default:            return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] mat_row(input logic [4:0] w);
        case (w)
            5'd6, 5'd7, 5'd8:    return 2'd0;
            5'd9, 5'd10, 5'd11:  return 2'd1;
            5'd12, 5'd13, 5'd14: return 2'd2;
            default:             return 2'd0;
        endcase
    endfunction

    // shift-subtract division for the table build, quotient high and remainder low
    function automatic logic [127:0] long_divide(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return {q, rem[63:0]};
    endfunction

    // tanh table over [0,4), built at elaboration
    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t    rom;
        logic [63:0]  step;
        logic [63:0]  term;
        logic [63:0]  e;
        logic [63:0]  dv;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  ah;
        logic [63:0]  al;
        logic [63:0]  bh;
        logic [63:0]  bl;
        logic [63:0]  lo;
        logic [63:0]  mid;
        logic [63:0]  lowp;
        logic [63:0]  quo;
        logic [127:0] qr;
        int           k;
        step = ONE_Q62;
        term = ONE_Q62;
        e    = ONE_Q62;
        k    = 1;
        while (term != 64'd0 && k < 64)
        begin
            dv   = 64'(TANH_ENTRIES) * 64'(k);
            qr   = long_divide(term, dv);
            quo  = qr[127:64];
            qr   = long_divide(qr[63:0] * 64'd8, dv);
            term = quo * 64'd8 + qr[127:64];
            if ((k & 1) == 1)
                step = step - term;
            else
                step = step + term;
            k = k + 1;
        end
        for (int i = 0; i < TANH_ENTRIES; i++)
        begin
            num    = (ONE_Q62 - e) >> 16;
            den    = (ONE_Q62 + e) >> 16;
            qr     = long_divide((num << 16) + (den >> 1), den);
            rom[i] = 17'(qr[127:64]);
            ah     = e >> 32;
            al     = e & 64'hFFFF_FFFF;
            bh     = step >> 32;
            bl     = step & 64'hFFFF_FFFF;
            lo     = al * bl;
            mid    = ah * bl + al * bh;
            lowp   = ((mid & 64'h3FFF_FFFF) + (lo >> 32)) >> 30;
            e      = ((ah * bh) << 2) + (mid >> 30) + lowp;
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

// ===== rtl/obfe_ctrl.sv =====
// controller state machine: sequences box loads, axis windows and the result strobe
module obfe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    input  logic                 wr_ok,
    input  logic [3:0]           box_count,
    input  logic [1:0]           dimension_count,
    input  obfe_pkg::dp_stat_t   stat,
    output obfe_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    obfe_pkg::obfe_state_t             state_reg, state_next;
    logic [obfe_pkg::BOX_CNT_W-1:0]    box_reg, box_next;
    logic [obfe_pkg::BOX_CNT_W-1:0]    nbox_reg, nbox_next;
    logic [4:0]                        step_reg, step_next;
    logic [1:0]                        axis_reg, axis_next;
    logic                              more_boxes;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= obfe_pkg::ST_IDLE;
            box_reg   <= '0;
            nbox_reg  <= '0;
            step_reg  <= '0;
            axis_reg  <= '0;
        end else begin
            state_reg <= state_next;
            box_reg   <= box_next;
            nbox_reg  <= nbox_next;
            step_reg  <= step_next;
            axis_reg  <= axis_next;
        end
    end

    assign more_boxes = ({1'b0, box_reg} + 1'b1) < {1'b0, nbox_reg};

    always_comb begin
        state_next = state_reg;
        box_next   = box_reg;
        nbox_next  = nbox_reg;
        step_next  = step_reg;
        axis_next  = axis_reg;
        cmd.wr_en  = 1'b0;
        cmd.rd_en  = 1'b0;
        cmd.box    = box_reg[obfe_pkg::BOX_IDX_W-1:0];
        cmd.word   = obfe_pkg::load_word(step_reg);
        cmd.axis   = axis_reg;
        cmd.op     = obfe_pkg::OP_NONE;
        done       = 1'b0;
        case (state_reg)
            obfe_pkg::ST_IDLE: begin
                if (start) begin
                    if (kind == obfe_pkg::KIND_POINT) begin
                        cmd.op    = obfe_pkg::OP_POINT;
                        box_next  = '0;
                        step_next = '0;
                        if (box_count > 4'(obfe_pkg::MAX_BOXES))
                            nbox_next = obfe_pkg::BOX_CNT_W'(obfe_pkg::MAX_BOXES);
                        else
                            nbox_next = obfe_pkg::BOX_CNT_W'(box_count);
                        if (box_count == 4'd0)
                            state_next = obfe_pkg::ST_DONE;
                        else
                            state_next = obfe_pkg::ST_LOAD;
                    end else begin
                        cmd.wr_en = wr_ok;
                    end
                end
            end
            obfe_pkg::ST_LOAD: begin
                cmd.rd_en = 1'b1;
                if (step_reg == obfe_pkg::LAST_STEP)
                    state_next = obfe_pkg::ST_DRAIN1;
                else
                    step_next = step_reg + 5'd1;
            end
            obfe_pkg::ST_DRAIN1: begin
                cmd.op     = obfe_pkg::OP_BOX_INIT;
                state_next = obfe_pkg::ST_DRAIN2;
            end
            obfe_pkg::ST_DRAIN2: begin
                axis_next = '0;
                if (stat.k_zero)
                    state_next = obfe_pkg::ST_SHARP;
                else
                    state_next = obfe_pkg::ST_AXSEL;
            end
            obfe_pkg::ST_SHARP: begin
                cmd.op = obfe_pkg::OP_SHARP;
                if (more_boxes) begin
                    box_next   = box_reg + 1'b1;
                    step_next  = '0;
                    state_next = obfe_pkg::ST_LOAD;
                end else begin
                    state_next = obfe_pkg::ST_DONE;
                end
            end
            obfe_pkg::ST_AXSEL: begin
                if (axis_reg >= dimension_count)
                    state_next = obfe_pkg::ST_BPROD;
                else if (stat.len_nz[axis_reg])
                    state_next = obfe_pkg::ST_MUL_P;
                else
                    axis_next = axis_reg + 2'd1;
            end
            obfe_pkg::ST_MUL_P: begin
                cmd.op     = obfe_pkg::OP_TMUL_P;
                state_next = obfe_pkg::ST_LOOK_P;
            end
            obfe_pkg::ST_LOOK_P: begin
                cmd.op     = obfe_pkg::OP_TLOOK;
                state_next = obfe_pkg::ST_SAVE_P;
            end
            obfe_pkg::ST_SAVE_P: begin
                cmd.op     = obfe_pkg::OP_TSAVE_P;
                state_next = obfe_pkg::ST_MUL_M;
            end
            obfe_pkg::ST_MUL_M: begin
                cmd.op     = obfe_pkg::OP_TMUL_M;
                state_next = obfe_pkg::ST_LOOK_M;
            end
            obfe_pkg::ST_LOOK_M: begin
                cmd.op     = obfe_pkg::OP_TLOOK;
                state_next = obfe_pkg::ST_SAVE_M;
            end
            obfe_pkg::ST_SAVE_M: begin
                cmd.op     = obfe_pkg::OP_TSAVE_M;
                state_next = obfe_pkg::ST_WIN;
            end
            obfe_pkg::ST_WIN: begin
                cmd.op     = obfe_pkg::OP_WIN;
                axis_next  = axis_reg + 2'd1;
                state_next = obfe_pkg::ST_AXSEL;
            end
            obfe_pkg::ST_BPROD: begin
                cmd.op     = obfe_pkg::OP_BPROD;
                state_next = obfe_pkg::ST_BFIN;
            end
            obfe_pkg::ST_BFIN: begin
                cmd.op = obfe_pkg::OP_BFIN;
                if (more_boxes) begin
                    box_next   = box_reg + 1'b1;
                    step_next  = '0;
                    state_next = obfe_pkg::ST_LOAD;
                end else begin
                    state_next = obfe_pkg::ST_DONE;
                end
            end
            obfe_pkg::ST_DONE: begin
                done       = 1'b1;
                state_next = obfe_pkg::ST_IDLE;
            end
            default: begin
                state_next = obfe_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != obfe_pkg::ST_IDLE);

endmodule

// ===== rtl/obfe_datapath.sv =====
// datapath: box word memory, frame transform, tanh table and box value maximum
module obfe_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  obfe_pkg::dp_cmd_t   cmd,
    input  logic [2:0]          box_slot,
    input  logic [4:0]          word_slot,
    input  logic signed [31:0]  word_data,
    input  logic signed [31:0]  px,
    input  logic signed [31:0]  py,
    input  logic signed [31:0]  pz,
    input  logic [1:0]          dimension_count,
    output obfe_pkg::dp_stat_t  stat,
    output logic signed [31:0]  field_value
);

    logic [31:0]                    mem [obfe_pkg::MEM_DEPTH];
    logic [obfe_pkg::ADDR_W-1:0]    wr_addr;
    logic [obfe_pkg::ADDR_W-1:0]    rd_addr;
    logic signed [31:0]             rdata_reg;
    logic                           rd_valid_reg;
    logic [4:0]                     word_reg;
    logic                           mac_valid_reg;
    logic [4:0]                     mac_word_reg;

    logic signed [31:0]             p_reg [3];
    logic signed [31:0]             d_reg [3];
    logic signed [31:0]             len_reg [3];
    logic signed [31:0]             u_reg [3];
    logic signed [31:0]             inside_reg;
    logic signed [31:0]             outside_reg;
    logic signed [31:0]             k_reg;
    logic signed [63:0]             prod_reg;
    logic signed [35:0]             acc_reg;
    logic [65:0]                    mag_reg;
    logic                           neg_reg;
    logic                           neg_q_reg;
    logic                           sat_reg;
    logic [16:0]                    rom_reg;
    logic signed [17:0]             tp_reg;
    logic signed [17:0]             tm_reg;
    logic signed [17:0]             window_reg;
    logic signed [50:0]             bprod_reg;
    logic signed [31:0]             result_reg;

    logic signed [33:0]             term;
    logic signed [35:0]             acc_sum;
    logic signed [34:0]             t_val;
    logic [33:0]                    t_mag;
    logic [31:0]                    k_mag;
    logic [obfe_pkg::SCALED_W-1:0]  scaled;
    logic [obfe_pkg::TIDX_W-1:0]    rom_idx;
    logic signed [17:0]             lut_mag;
    logic signed [17:0]             lut_val;
    logic signed [18:0]             win_diff;
    logic signed [17:0]             win_half;
    logic signed [35:0]             win_prod;
    logic signed [32:0]             io_diff;
    logic signed [35:0]             box_sum;
    logic signed [31:0]             smooth_val;
    logic                           out_any;
    logic signed [31:0]             sharp_val;

    assign wr_addr = obfe_pkg::ADDR_W'(box_slot) * obfe_pkg::ADDR_W'(obfe_pkg::WORDS_PER_BOX)
                   + obfe_pkg::ADDR_W'(word_slot);
    assign rd_addr = obfe_pkg::ADDR_W'(cmd.box) * obfe_pkg::ADDR_W'(obfe_pkg::WORDS_PER_BOX)
                   + obfe_pkg::ADDR_W'(cmd.word);

    always_ff @(posedge clk) begin
        if (cmd.wr_en)
            mem[wr_addr] <= word_data;
        if (cmd.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rd_valid_reg  <= 1'b0;
            mac_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= cmd.rd_en;
            mac_valid_reg <= rd_valid_reg && (word_reg >= obfe_pkg::W_MATRIX)
                             && (word_reg <= obfe_pkg::W_MAT_END);
        end
    end

    always_comb begin
        term     = 34'(prod_reg >>> 30);
        acc_sum  = acc_reg + 36'(term);

        if (cmd.op == obfe_pkg::OP_TMUL_M)
            t_val = (35'(u_reg[cmd.axis]) <<< 1) - 35'(len_reg[cmd.axis]);
        else
            t_val = (35'(u_reg[cmd.axis]) <<< 1) + 35'(len_reg[cmd.axis]);
        t_mag = t_val[34] ? 34'(-t_val) : 34'(t_val);
        k_mag = k_reg[31] ? 32'(-(33'(k_reg))) : 32'(k_reg);

        scaled  = obfe_pkg::SCALED_W'(mag_reg[34:0])
                * obfe_pkg::SCALED_W'(obfe_pkg::TANH_ENTRIES);
        rom_idx = scaled[35 +: obfe_pkg::TIDX_W];

        lut_mag = sat_reg ? obfe_pkg::ONE_Q16 : $signed({1'b0, rom_reg});
        lut_val = neg_q_reg ? -lut_mag : lut_mag;

        win_diff = 19'(tp_reg) - 19'(tm_reg);
        win_half = 18'(win_diff >>> 1);
        win_prod = window_reg * win_half;

        io_diff    = 33'(inside_reg) - 33'(outside_reg);
        box_sum    = 36'(outside_reg) + 36'(bprod_reg >>> 16);
        smooth_val = obfe_pkg::sat32(64'(box_sum));

        out_any = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (2'(a) < dimension_count) begin
                if (((34'(u_reg[a]) <<< 1) < -34'(len_reg[a]))
                    || ((34'(u_reg[a]) <<< 1) > 34'(len_reg[a])))
                    out_any = 1'b1;
            end
        end
        sharp_val = out_any ? outside_reg : inside_reg;
    end

    // word loads and matrix products, one word per cycle
    always_ff @(posedge clk) begin
        word_reg     <= cmd.word;
        mac_word_reg <= word_reg;
        if (rd_valid_reg) begin
            case (word_reg) inside
                [obfe_pkg::W_CENTER : obfe_pkg::W_CENTER + 5'd2]:
                    d_reg[2'(word_reg - obfe_pkg::W_CENTER)] <=
                        obfe_pkg::sat32(64'(p_reg[2'(word_reg - obfe_pkg::W_CENTER)])
                                        - 64'(rdata_reg));
                [obfe_pkg::W_LENGTH : obfe_pkg::W_LENGTH + 5'd2]:
                    len_reg[2'(word_reg - obfe_pkg::W_LENGTH)] <= rdata_reg;
                [obfe_pkg::W_MATRIX : obfe_pkg::W_MAT_END]:
                    prod_reg <= 64'(rdata_reg) * 64'(d_reg[obfe_pkg::mat_col(word_reg)]);
                obfe_pkg::W_INSIDE:
                    inside_reg <= rdata_reg;
                obfe_pkg::W_OUTSIDE:
                    outside_reg <= rdata_reg;
                obfe_pkg::W_SCALE:
                    k_reg <= rdata_reg;
                default: ;
            endcase
        end
        if (mac_valid_reg) begin
            if (obfe_pkg::mat_col(mac_word_reg) == 2'd0)
                acc_reg <= 36'(term);
            else
                acc_reg <= acc_sum;
            if (obfe_pkg::mat_col(mac_word_reg) == 2'd2)
                u_reg[obfe_pkg::mat_row(mac_word_reg)] <= obfe_pkg::sat32(64'(acc_sum));
        end
    end

    // per-box window and result operations
    always_ff @(posedge clk) begin
        case (cmd.op)
            obfe_pkg::OP_POINT: begin
                p_reg[0]   <= px;
                p_reg[1]   <= py;
                p_reg[2]   <= pz;
                result_reg <= '0;
            end
            obfe_pkg::OP_BOX_INIT: begin
                window_reg <= obfe_pkg::ONE_Q16;
            end
            obfe_pkg::OP_TMUL_P, obfe_pkg::OP_TMUL_M: begin
                mag_reg <= 66'(t_mag) * 66'(k_mag);
                neg_reg <= t_val[34] ^ k_reg[31];
            end
            obfe_pkg::OP_TLOOK: begin
                sat_reg   <= |mag_reg[65:35];
                rom_reg   <= obfe_pkg::TANH_ROM[rom_idx];
                neg_q_reg <= neg_reg;
            end
            obfe_pkg::OP_TSAVE_P: begin
                tp_reg <= lut_val;
            end
            obfe_pkg::OP_TSAVE_M: begin
                tm_reg <= lut_val;
            end
            obfe_pkg::OP_WIN: begin
                window_reg <= 18'(win_prod >>> 16);
            end
            obfe_pkg::OP_SHARP: begin
                if (sharp_val > result_reg)
                    result_reg <= sharp_val;
            end
            obfe_pkg::OP_BPROD: begin
                bprod_reg <= 51'(io_diff) * 51'(window_reg);
            end
            obfe_pkg::OP_BFIN: begin
                if (smooth_val > result_reg)
                    result_reg <= smooth_val;
            end
            default: ;
        endcase
    end

    assign stat.k_zero    = (k_reg == 32'sd0);
    assign stat.len_nz[0] = (len_reg[0] != 32'sd0);
    assign stat.len_nz[1] = (len_reg[1] != 32'sd0);
    assign stat.len_nz[2] = (len_reg[2] != 32'sd0);
    assign field_value    = result_reg;

endmodule

// ===== rtl/oriented_box_field_evaluator_unit.sv =====
// top level of the oriented box field evaluator: config registers, controller, datapath
//
//  channel   handshake                  payload
//  request   start / busy               kind, box_slot, word_slot, word_data, px, py, pz
//  result    done (one-cycle strobe)    field_value
//  config    cfg_write                  cfg_index, cfg_data
//
// a word write leaves busy low
// a point loads each box in turn, one word a cycle from the box word memory, then takes the
// sharp path (scale zero) or the smooth path over each nonzero-length axis, and the tanh table
// is read twice per smoothed axis
// done pulses for one cycle with field_value; the receiver cannot stall it
// reset clears control state and config (box_count 0, dimension_count 3); box words are
// undefined until written
module oriented_box_field_evaluator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [2:0]         box_slot,
    input  logic [4:0]         word_slot,
    input  logic signed [31:0] word_data,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    output logic               done,
    output logic signed [31:0] field_value,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data
);

    logic [3:0]          box_count_reg;
    logic [1:0]          dimension_count_reg;
    logic                wr_ok;
    obfe_pkg::dp_cmd_t   cmd;
    obfe_pkg::dp_stat_t  stat;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            box_count_reg       <= 4'd0;
            dimension_count_reg <= 2'd3;
        end else if (cfg_write) begin
            if (cfg_index == obfe_pkg::CFG_BOX_COUNT)
                box_count_reg <= cfg_data;
            else
                dimension_count_reg <= cfg_data[1:0];
        end
    end

    assign wr_ok = (int'(box_slot) < obfe_pkg::MAX_BOXES) && (word_slot <= obfe_pkg::W_SCALE);

    obfe_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .kind            (kind),
        .wr_ok           (wr_ok),
        .box_count       (box_count_reg),
        .dimension_count (dimension_count_reg),
        .stat            (stat),
        .cmd             (cmd),
        .busy            (busy),
        .done            (done)
    );

    obfe_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .box_slot        (box_slot),
        .word_slot       (word_slot),
        .word_data       (word_data),
        .px              (px),
        .py              (py),
        .pz              (pz),
        .dimension_count (dimension_count_reg),
        .stat            (stat),
        .field_value     (field_value)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == obfe_pkg::KIND_POINT) |=> busy)
        else $error("point request did not start evaluation");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == obfe_pkg::KIND_WRITE) |=> !busy && !done)
        else $error("word write started evaluation");

endmodule

// ===== bench/oriented_box_field_evaluator_unit_tb.sv =====
// self-checking testbench of the oriented box field evaluator: directed and random requests
`timescale 1ns / 1ps

module oriented_box_field_evaluator_unit_tb;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               kind;
    logic [2:0]         box_slot;
    logic [4:0]         word_slot;
    logic signed [31:0] word_data;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               done;
    logic signed [31:0] field_value;
    logic               cfg_write;
    logic               cfg_index;
    logic [3:0]         cfg_data;

    oriented_box_field_evaluator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .box_slot(box_slot), .word_slot(word_slot), .word_data(word_data),
        .px(px), .py(py), .pz(pz), .done(done), .field_value(field_value),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam longint ONE = 65536;

    logic signed [31:0] box_mem [obfe_pkg::WORDS_PER_BOX * obfe_pkg::MAX_BOXES];
    int                 tanh_tbl [obfe_pkg::TANH_ENTRIES];
    int unsigned        active_boxes;
    int unsigned        axis_count;
    logic signed [31:0] field_queue [$];
    int                 errors;
    bit                 idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("oriented_box_field_evaluator_unit: mismatch");
        $finish;
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned q62_mul(longint unsigned a, longint unsigned b);
        longint unsigned ah, al, bh, bl, lo, mid, lowp;
        ah   = a >> 32;
        al   = a & 64'hFFFF_FFFF;
        bh   = b >> 32;
        bl   = b & 64'hFFFF_FFFF;
        lo   = al * bl;
        mid  = ah * bl + al * bh;
        lowp = ((mid & 64'h3FFF_FFFF) + (lo >> 32)) >> 30;
        return ((ah * bh) << 2) + (mid >> 30) + lowp;
    endfunction

    // tanh(4i/N) in Q16.16 from exp(-8/N) stepped in Q2.62
    function automatic void fill_tanh_table();
        longint unsigned unit_q62, decay, term, ex, dv, num, den;
        int              n;
        unit_q62 = 64'h4000_0000_0000_0000;
        decay    = unit_q62;
        term     = unit_q62;
        ex       = unit_q62;
        n        = 1;
        while (term != 0 && n < 64)
        begin
            dv   = longint'(obfe_pkg::TANH_ENTRIES) * n;
            term = (term / dv) * 8 + ((term % dv) * 8) / dv;
            if (n % 2 == 1)
                decay = decay - term;
            else
                decay = decay + term;
            n++;
        end
        for (int i = 0; i < obfe_pkg::TANH_ENTRIES; i++)
        begin
            num         = (unit_q62 - ex) >> 16;
            den         = (unit_q62 + ex) >> 16;
            tanh_tbl[i] = int'(((num << 16) + den / 2) / den);
            ex          = q62_mul(ex, decay);
        end
    endfunction

    function automatic longint tanh_of(longint t, longint k);
        bit              neg;
        longint unsigned mt, mk, mag;
        longint          v;
        neg = (t < 0) != (k < 0);
        mt  = (t < 0) ? -t : t;
        mk  = (k < 0) ? -k : k;
        mag = mt * mk;
        if (mag >= (64'd1 << 35))
            v = ONE;
        else
            v = tanh_tbl[(mag * obfe_pkg::TANH_ENTRIES) >> 35];
        return neg ? -v : v;
    endfunction

    function automatic longint word_of(int b, int w);
        return longint'(box_mem[b * obfe_pkg::WORDS_PER_BOX + w]);
    endfunction

    function automatic longint box_field(int b, longint p [3]);
        longint d [3];
        longint u [3];
        longint inside_v, outside_v, k, s, l, win, diff;
        inside_v  = word_of(b, obfe_pkg::W_INSIDE);
        outside_v = word_of(b, obfe_pkg::W_OUTSIDE);
        k         = word_of(b, obfe_pkg::W_SCALE);
        for (int a = 0; a < 3; a++)
            d[a] = clamp32(p[a] - word_of(b, obfe_pkg::W_CENTER + a));
        for (int r = 0; r < 3; r++)
        begin
            s = 0;
            for (int c = 0; c < 3; c++)
                s += (word_of(b, obfe_pkg::W_MATRIX + 3 * r + c) * d[c]) >>> 30;
            u[r] = clamp32(s);
        end
        if (k == 0)
        begin
            for (int a = 0; a < axis_count; a++)
            begin
                l = word_of(b, obfe_pkg::W_LENGTH + a);
                if (2 * u[a] < -l || 2 * u[a] > l)
                    return outside_v;
            end
            return inside_v;
        end
        win = ONE;
        for (int a = 0; a < axis_count; a++)
        begin
            l = word_of(b, obfe_pkg::W_LENGTH + a);
            if (l != 0)
            begin
                diff = tanh_of(2 * u[a] + l, k) - tanh_of(2 * u[a] - l, k);
                win  = (win * (diff >>> 1)) >>> 16;
            end
        end
        return clamp32(outside_v + (((inside_v - outside_v) * win) >>> 16));
    endfunction

    function automatic logic signed [31:0] field_at(logic signed [31:0] x,
                                                     logic signed [31:0] y,
                                                     logic signed [31:0] z);
        longint p [3];
        longint best, v;
        int     n;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        best = 0;
        n    = (active_boxes > obfe_pkg::MAX_BOXES) ? obfe_pkg::MAX_BOXES : active_boxes;
        for (int b = 0; b < n; b++)
        begin
            v = box_field(b, p);
            if (v > best)
                best = v;
        end
        return best[31:0];
    endfunction

    task automatic send_request(logic k, logic [2:0] bs, logic [4:0] ws, logic [31:0] wd,
                                logic [31:0] x, logic [31:0] y, logic [31:0] z);
        kind      = k;
        box_slot  = bs;
        word_slot = ws;
        word_data = wd;
        px        = x;
        py        = y;
        pz        = z;
        start     = 1'b1;
        while (busy)
            @(negedge clk);
        if (k == obfe_pkg::KIND_POINT)
            field_queue = {field_queue, field_at(x, y, z)};
        else if (ws <= obfe_pkg::W_SCALE && bs < obfe_pkg::MAX_BOXES)
            box_mem[bs * obfe_pkg::WORDS_PER_BOX + ws] = wd;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_word(int b, int w, logic [31:0] v);
        send_request(obfe_pkg::KIND_WRITE, 3'(b), 5'(w), v, $urandom, $urandom, $urandom);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_request(obfe_pkg::KIND_POINT, 3'($urandom), 5'($urandom), $urandom, x, y, z);
    endtask

    task automatic set_reg(logic idx, logic [3:0] v);
        while (field_queue.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == obfe_pkg::CFG_BOX_COUNT)
            active_boxes = v;
        else
            axis_count = v[1:0];
    endtask

    function automatic logic [31:0] plausible_word(int w);
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        if (w < obfe_pkg::W_LENGTH)
            return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        if (w < obfe_pkg::W_MATRIX)
            return ($urandom_range(0, 9) == 0) ? -32'sd65536 : $urandom_range(0, 1 << 18);
        if (w <= obfe_pkg::W_MAT_END)
            return 32'(int'($urandom_range(0, 1 << 31)) - (1 << 30));
        if (w < obfe_pkg::W_SCALE)
            return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        case ($urandom_range(0, 5))
            0, 1: return 32'd0;
            2:    return -32'sd65536;
            default: return $urandom_range(1 << 13, 1 << 17);
        endcase
    endfunction

    task automatic load_box(int b, bit sharp, bit aligned);
        for (int w = 0; w <= obfe_pkg::W_SCALE; w++)
        begin
            if (aligned && w >= obfe_pkg::W_MATRIX && w <= obfe_pkg::W_MAT_END)
                write_word(b, w, ((w - obfe_pkg::W_MATRIX) % 4 == 0) ? 32'sh4000_0000 : 32'd0);
            else if (w == obfe_pkg::W_SCALE)
                write_word(b, w, sharp ? 32'd0 : plausible_word(w) | 32'd1);
            else
                write_word(b, w, plausible_word(w));
        end
    endtask

    task automatic near_point(int b);
        send_point(box_mem[b * obfe_pkg::WORDS_PER_BOX]
                       + int'($urandom_range(0, 1 << 19)) - (1 << 18),
                   box_mem[b * obfe_pkg::WORDS_PER_BOX + 1]
                       + int'($urandom_range(0, 1 << 19)) - (1 << 18),
                   box_mem[b * obfe_pkg::WORDS_PER_BOX + 2]
                       + int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endtask

    task automatic random_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 13)) @(negedge clk);
    endtask

    task automatic test_reset_state();
        send_point(0, 0, 0);
        for (int b = 0; b < obfe_pkg::MAX_BOXES; b++)
            load_box(b, 1'b1, 1'b1);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    endtask

    task automatic test_sharp_edges();
        set_reg(obfe_pkg::CFG_BOX_COUNT, 4'd1);
        write_word(0, obfe_pkg::W_CENTER, 0);
        write_word(0, obfe_pkg::W_CENTER + 1, 0);
        write_word(0, obfe_pkg::W_CENTER + 2, 0);
        for (int a = 0; a < 3; a++)
            write_word(0, obfe_pkg::W_LENGTH + a, 32'sd131072);
        write_word(0, obfe_pkg::W_INSIDE, 32'sd65536);
        write_word(0, obfe_pkg::W_OUTSIDE, 32'sd32768);
        write_word(0, obfe_pkg::W_SCALE, 0);
        send_point(32'sd65536, 0, 0);
        send_point(32'sd65537, 0, 0);
        send_point(-32'sd65536, 32'sd65536, -32'sd65536);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        set_reg(obfe_pkg::CFG_DIM_COUNT, 4'd1);
        send_point(0, 32'sd900000, 0);
        set_reg(obfe_pkg::CFG_DIM_COUNT, 4'd0);
        send_point(32'sd900000, 0, 0);
        set_reg(obfe_pkg::CFG_DIM_COUNT, 4'd3);
        write_word(0, obfe_pkg::W_LENGTH, -32'sd1);
        send_point(0, 0, 0);
        write_word(0, obfe_pkg::W_INSIDE, 32'sh7FFF_FFFF);
        write_word(0, obfe_pkg::W_OUTSIDE, 32'sh8000_0000);
        write_word(0, obfe_pkg::W_LENGTH, 32'sd131072);
        write_word(0, obfe_pkg::W_SCALE, 32'sd65536);
        send_point(0, 0, 0);
        write_word(0, obfe_pkg::W_SCALE, -32'sd65536);
        send_point(32'sd40000, 0, 0);
        write_word(7, 31, 32'hFFFF_FFFF);
        write_word(3, 18, 32'hFFFF_FFFF);
        send_point(0, 0, 0);
    endtask

    task automatic test_box_counts();
        set_reg(obfe_pkg::CFG_BOX_COUNT, 4'd8);
        send_point(0, 0, 0);
        set_reg(obfe_pkg::CFG_BOX_COUNT, 4'd15);
        send_point(32'sd65536, -32'sd65536, 0);
        set_reg(obfe_pkg::CFG_DIM_COUNT, 4'd14);
        send_point(0, 0, 0);
        set_reg(obfe_pkg::CFG_DIM_COUNT, 4'd3);
    endtask

    task automatic run_random(int items, bit allow_idle);
        int b;
        for (int i = 0; i < items; i++)
        begin
            if (i % 150 == 0)
            begin
                idle_on = allow_idle && ($urandom_range(0, 2) != 0);
                set_reg(obfe_pkg::CFG_BOX_COUNT,
                        4'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 8)));
                set_reg(obfe_pkg::CFG_DIM_COUNT, 4'($urandom));
            end
            random_gap();
            b = $urandom_range(0, obfe_pkg::MAX_BOXES - 1);
            case ($urandom_range(0, 19))
                0:       load_box(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                1:       send_point($urandom, $urandom, $urandom);
                2:       write_word(b, $urandom_range(18, 31), $urandom);
                3, 4, 5: begin
                    b = $urandom_range(0, 17);
                    write_word($urandom_range(0, 7), b, plausible_word(b));
                end
                default: near_point($urandom_range(0, obfe_pkg::MAX_BOXES - 1));
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (field_queue.size() == 0)
            begin
                $error("field_value: no request pending, actual %0d", field_value);
                errors++;
            end
            else
            begin
                if (field_value !== field_queue[0])
                begin
                    $error("field_value: expected %0d actual %0d", field_queue[0], field_value);
                    errors++;
                end
                void'(field_queue.pop_front());
            end
        end
    end

    initial
    begin
        errors       = 0;
        idle_on      = 1'b0;
        active_boxes = 0;
        axis_count   = 3;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = obfe_pkg::KIND_WRITE;
        box_slot     = '0;
        word_slot    = '0;
        word_data    = '0;
        px           = '0;
        py           = '0;
        pz           = '0;
        cfg_write    = 1'b0;
        cfg_index    = obfe_pkg::CFG_BOX_COUNT;
        cfg_data     = '0;
        for (int i = 0; i < obfe_pkg::WORDS_PER_BOX * obfe_pkg::MAX_BOXES; i++)
            box_mem[i] = '0;
        fill_tanh_table();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_sharp_edges();
        test_box_counts();
        run_random(800, 1'b1);
        idle_on = 1'b0;
        run_random(200, 1'b0);

        while (field_queue.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (errors == 0)
            $display("oriented_box_field_evaluator_unit: match");
        else
            $display("oriented_box_field_evaluator_unit: mismatch");
        $finish;
    end

endmodule
